### design/escape_sequence_decoder_assert.svh
// Assertion macros for the escape sequence decoder checker
`ifndef ESCAPE_SEQUENCE_DECODER_ASSERT_SVH
`define ESCAPE_SEQUENCE_DECODER_ASSERT_SVH

// Clocked property, disabled while reset is asserted
`define ESD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// A result that is shown but not taken holds its value
`define ESD_ASSERT_HOLD(label, sig, msg) \
	`ESD_ASSERT(label, (!empty && !pop) |=> (!empty && $stable(sig)), msg)

`endif

### design/esd_pkg.sv
// Shared types, constants and character helpers for the escape sequence decoder
`timescale 1ns / 1ps

package esd_pkg;

	// Default depth of the request queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// Character codes
	localparam logic [7:0] CHAR_BSLASH = 8'h5C;
	localparam logic [7:0] CHAR_0      = 8'h30;
	localparam logic [7:0] CHAR_7      = 8'h37;
	localparam logic [7:0] CHAR_9      = 8'h39;
	localparam logic [7:0] CHAR_LA     = 8'h61;
	localparam logic [7:0] CHAR_LF     = 8'h66;
	localparam logic [7:0] CHAR_UA     = 8'h41;
	localparam logic [7:0] CHAR_UF     = 8'h46;
	localparam logic [7:0] CHAR_LX     = 8'h78;
	localparam logic [7:0] CHAR_UX     = 8'h58;
	localparam logic [7:0] ESC_BYTE    = 8'h1B;

	// Longest numeric escapes
	localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;
	localparam logic [1:0] HEX_MAX_DIGITS = 2'd2;

	// One request: up to two decoded bytes, then an optional terminating zero
	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [1:0] data_count;
		logic       term;
	} esd_req_t;

	function automatic logic is_oct(input logic [7:0] c);
		return (c >= CHAR_0) && (c <= CHAR_7);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= CHAR_0) && (c <= CHAR_9)) ||
			((c >= CHAR_LA) && (c <= CHAR_LF)) ||
			((c >= CHAR_UA) && (c <= CHAR_UF));
	endfunction

	// Nibble value of a hex digit; letters sit one above 0x40/0x60
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] v;
		if ((c >= CHAR_0) && (c <= CHAR_9)) begin
			v = c[3:0];
		end else begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

	// Single-character escapes; anything else stands for itself
	function automatic logic [7:0] simple_escape(input logic [7:0] c);
		logic [7:0] v;
		case (c)
			8'h6E:   v = 8'h0A; // n
			8'h74:   v = 8'h09; // t
			8'h72:   v = 8'h0D; // r
			8'h62:   v = 8'h08; // b
			8'h66:   v = 8'h0C; // f
			8'h76:   v = 8'h0B; // v
			8'h61:   v = 8'h07; // a
			8'h65:   v = ESC_BYTE; // e
			default: v = c;
		endcase
		return v;
	endfunction

endpackage

### design/esd_front.sv
// Front end: accepts characters, tracks escape state and builds byte requests
`timescale 1ns / 1ps

module esd_front import esd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] char_in,
	input  logic       char_last,
	input  logic       q_full,
	output logic       wr_en,
	output esd_req_t   wr_req
);

	typedef enum logic [1:0] {
		MODE_PLAIN,
		MODE_ESC,
		MODE_OCT,
		MODE_HEX
	} mode_t;

	mode_t      mode_q, mode_d;
	logic [7:0] value_q, value_d;
	logic [1:0] count_q, count_d;
	logic       accept;
	logic       do_plain;
	logic [7:0] next_val;
	logic [1:0] next_cnt;
	esd_req_t   req;

	assign accept = push && !q_full;

	// Classify the character and work out the bytes it completes
	always_comb begin
		mode_d   = mode_q;
		value_d  = value_q;
		count_d  = count_q;
		req      = '0;
		do_plain = 1'b0;
		next_val = '0;
		next_cnt = count_q + 2'd1;
		case (mode_q)
			MODE_PLAIN: begin
				do_plain = 1'b1;
			end
			MODE_ESC: begin
				if (is_oct(char_in)) begin
					value_d = {5'd0, char_in[2:0]};
					count_d = 2'd1;
					mode_d  = MODE_OCT;
					if (char_last) begin
						req.byte0      = value_d;
						req.data_count = 2'd1;
					end
				end else if ((char_in == CHAR_LX) || (char_in == CHAR_UX)) begin
					value_d = '0;
					count_d = '0;
					mode_d  = MODE_HEX;
					if (char_last) begin
						req.byte0      = '0;
						req.data_count = 2'd1;
					end
				end else begin
					req.byte0      = simple_escape(char_in);
					req.data_count = 2'd1;
					mode_d         = MODE_PLAIN;
				end
			end
			MODE_OCT: begin
				if (is_oct(char_in)) begin
					next_val = {value_q[4:0], char_in[2:0]};
					if ((next_cnt == OCT_MAX_DIGITS) || char_last) begin
						req.byte0      = next_val;
						req.data_count = 2'd1;
						mode_d         = MODE_PLAIN;
						value_d        = '0;
						count_d        = '0;
					end else begin
						value_d = next_val;
						count_d = next_cnt;
					end
				end else begin
					req.byte0      = value_q;
					req.data_count = 2'd1;
					value_d        = '0;
					count_d        = '0;
					do_plain       = 1'b1;
				end
			end
			MODE_HEX: begin
				if (is_hex(char_in)) begin
					next_val = {value_q[3:0], hex_val(char_in)};
					if ((next_cnt == HEX_MAX_DIGITS) || char_last) begin
						req.byte0      = next_val;
						req.data_count = 2'd1;
						mode_d         = MODE_PLAIN;
						value_d        = '0;
						count_d        = '0;
					end else begin
						value_d = next_val;
						count_d = next_cnt;
					end
				end else begin
					req.byte0      = value_q;
					req.data_count = 2'd1;
					value_d        = '0;
					count_d        = '0;
					do_plain       = 1'b1;
				end
			end
			default: begin
				mode_d = MODE_PLAIN;
			end
		endcase

		// Plain character: open an escape, or pass the byte through
		if (do_plain) begin
			if ((char_in == CHAR_BSLASH) && !char_last) begin
				mode_d = MODE_ESC;
			end else begin
				if (req.data_count == 2'd0) begin
					req.byte0 = char_in;
				end else begin
					req.byte1 = char_in;
				end
				req.data_count = req.data_count + 2'd1;
				mode_d         = MODE_PLAIN;
			end
		end

		// End of literal: add the terminator and drop all state
		if (char_last) begin
			req.term = 1'b1;
			mode_d   = MODE_PLAIN;
			value_d  = '0;
			count_d  = '0;
		end
	end

	assign wr_en  = accept && ((req.data_count != 2'd0) || req.term);
	assign wr_req = req;

	// Advance decode state on each accepted character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PLAIN;
			value_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			value_q <= value_d;
			count_q <= count_d;
		end
	end

endmodule

### design/esd_fifo.sv
// Request queue between the decode front end and the byte serializer
`timescale 1ns / 1ps

module esd_fifo import esd_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_en,
	input  esd_req_t wr_req,
	output logic     full,
	input  logic     rd_en,
	output esd_req_t rd_req,
	output logic     rd_valid
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	esd_req_t         entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_FULL);
	assign rd_valid = (count_q != '0);
	assign rd_req   = entry_q[rd_ptr_q];

	// Store requests
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_req;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### design/esd_back.sv
// Back end: splits each request into bytes and holds the output register
`timescale 1ns / 1ps

module esd_back import esd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  esd_req_t   head,
	input  logic       head_valid,
	output logic       rd_en,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] byte_out,
	output logic       byte_last
);

	logic [1:0] idx_q;
	logic       out_vld_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       load;
	logic       final_byte;
	logic [1:0] total;
	logic [7:0] cur_byte;
	logic       cur_last;

	assign load       = head_valid && (!out_vld_q || pop);
	assign total      = head.data_count + {1'b0, head.term};
	assign final_byte = ((idx_q + 2'd1) == total);
	assign rd_en      = load && final_byte;

	// Pick the byte at the current position of the head request
	always_comb begin
		if (idx_q < head.data_count) begin
			cur_byte = (idx_q == 2'd0) ? head.byte0 : head.byte1;
			cur_last = 1'b0;
		end else begin
			cur_byte = '0;
			cur_last = 1'b1;
		end
	end

	// Advance position and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q     <= final_byte ? 2'd0 : idx_q + 2'd1;
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Load output data
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= cur_byte;
			out_last_q <= cur_last;
		end
	end

	assign empty     = !out_vld_q;
	assign byte_out  = out_byte_q;
	assign byte_last = out_last_q;

endmodule

### design/escape_sequence_decoder.sv
// A character's first byte is written into the request queue, then loaded into the output register.
// One character per cycle while each yields at most one byte and the output is popped; a
// character yielding more bytes keeps the byte serializer busy with one load per byte.
// Full rises when the request queue is full, from a stalled output or from requests of several bytes.
// Reset (arst_n low) returns to plain text and clears queue and output.
`timescale 1ns / 1ps

module escape_sequence_decoder import esd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = esd_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_in,
	input  logic       char_last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] byte_out,
	output logic       byte_last
);

	logic     wr_en;
	esd_req_t wr_req;
	logic     rd_en;
	esd_req_t rd_req;
	logic     rd_valid;

	esd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.char_in   (char_in),
		.char_last (char_last),
		.q_full    (full),
		.wr_en     (wr_en),
		.wr_req    (wr_req)
	);

	esd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_req   (wr_req),
		.full     (full),
		.rd_en    (rd_en),
		.rd_req   (rd_req),
		.rd_valid (rd_valid)
	);

	esd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (rd_req),
		.head_valid (rd_valid),
		.rd_en      (rd_en),
		.pop        (pop),
		.empty      (empty),
		.byte_out   (byte_out),
		.byte_last  (byte_last)
	);

endmodule

### design/esd_checker.sv
// Port-level checker for the escape sequence decoder, bound to the top level
`timescale 1ns / 1ps
`include "escape_sequence_decoder_assert.svh"

module esd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       char_last,
	input logic       empty,
	input logic       pop,
	input logic [7:0] byte_out,
	input logic       byte_last
);

	// Stalled output holds
	`ESD_ASSERT_HOLD(a_hold_byte, byte_out, "byte_out changed while stalled")
	`ESD_ASSERT_HOLD(a_hold_last, byte_last, "byte_last changed while stalled")

	// Terminator is always a zero byte
	`ESD_ASSERT(a_term_zero, (!empty && byte_last) |-> (byte_out == 8'h00), "terminator not zero")

	// Queue is full only while the output holds a byte
	`ESD_ASSERT(a_full_stall, full |-> !empty, "full while output is empty")

	// Output is present after an accepted last character
	`ESD_ASSERT(a_last_out, (push && !full && char_last) |-> ##2 !empty, "no result after last")

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (.*);

### verif/tb_escape_sequence_decoder.sv
// Self-checking testbench for the escape sequence decoder: queue-style driver, monitor, predictor
`timescale 1ns / 1ps

module tb_escape_sequence_decoder import esd_pkg::*;;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_ITEMS = 150;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200000;

	typedef enum logic [1:0] {MODE_PLAIN, MODE_ESC, MODE_OCT, MODE_HEX} dec_mode_t;
	typedef enum int {TOK_PLAIN, TOK_SIMPLE, TOK_OCT, TOK_HEX, TOK_UNKNOWN} token_t;
	typedef enum int {RX_FREE, RX_RANDOM, RX_SLOW} rx_pattern_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_req_t;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} dec_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] char_in = 8'h00;
	logic       char_last = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] byte_out;
	logic       byte_last;

	char_req_t   pending_chars[$];
	dec_byte_t   expected_bytes[$];
	int          mismatches = 0;
	int          cycle_count = 0;
	bit          push_stalled = 1'b0;
	int          gap_left = 0;
	int          burst_left = 4;
	rx_pattern_t rx_pattern = RX_FREE;
	int          rx_phase_left = 40;
	int          rx_slow_count = 0;

	// Predictor state
	dec_mode_t  pred_mode = MODE_PLAIN;
	logic [8:0] pred_value = '0;
	logic [1:0] pred_digits = '0;

	escape_sequence_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.char_in  (char_in),
		.char_last(char_last),
		.empty    (empty),
		.pop      (pop),
		.byte_out (byte_out),
		.byte_last(byte_last)
	);

	always #CLK_HALF clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	function automatic void add_char(input logic [7:0] ch, input logic last);
		pending_chars.push_back('{ch: ch, last: last});
	endfunction

	function automatic bit is_octal(input logic [7:0] c);
		return (c >= CHAR_0) && (c <= CHAR_7);
	endfunction

	function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
		v = '0;
		if (c >= "0" && c <= "9") begin
			v = 4'(c - "0");
			return 1'b1;
		end
		if (c >= "a" && c <= "f") begin
			v = 4'(c - "a" + 8'd10);
			return 1'b1;
		end
		if (c >= "A" && c <= "F") begin
			v = 4'(c - "A" + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] translate_escape(input logic [7:0] c);
		case (c)
			"n":     return 8'h0A;
			"t":     return 8'h09;
			"r":     return 8'h0D;
			"b":     return 8'h08;
			"f":     return 8'h0C;
			"v":     return 8'h0B;
			"a":     return 8'h07;
			"e":     return ESC_BYTE;
			default: return c;
		endcase
	endfunction

	function automatic void emit_byte(input logic [7:0] value, input logic last);
		expected_bytes.push_back('{value: value, last: last});
	endfunction

	function automatic void clear_numeric();
		pred_value = '0;
		pred_digits = '0;
	endfunction

	// Plain text: a backslash opens an escape unless it ends the literal
	function automatic void decode_plain(input logic [7:0] c, input logic last);
		if (c == CHAR_BSLASH && !last) begin
			pred_mode = MODE_ESC;
		end else begin
			emit_byte(c, 1'b0);
			pred_mode = MODE_PLAIN;
		end
	endfunction

	// Advance the predictor by one accepted character
	function automatic void decode_char(input logic [7:0] c, input logic last);
		logic [3:0] nib;
		bit         is_hex;
		is_hex = hex_digit(c, nib);
		case (pred_mode)
			MODE_PLAIN: begin
				decode_plain(c, last);
			end
			MODE_ESC: begin
				if (is_octal(c)) begin
					pred_value = 9'(c - CHAR_0);
					pred_digits = 2'd1;
					pred_mode = MODE_OCT;
					if (last) emit_byte(pred_value[7:0], 1'b0);
				end else if (c == CHAR_LX || c == CHAR_UX) begin
					clear_numeric();
					pred_mode = MODE_HEX;
					if (last) emit_byte(8'h00, 1'b0);
				end else begin
					emit_byte(translate_escape(c), 1'b0);
					pred_mode = MODE_PLAIN;
				end
			end
			MODE_OCT: begin
				if (is_octal(c) && pred_digits < OCT_MAX_DIGITS) begin
					pred_value = (pred_value << 3) + 9'(c - CHAR_0);
					pred_digits = pred_digits + 2'd1;
					if (pred_digits >= OCT_MAX_DIGITS || last) begin
						emit_byte(pred_value[7:0], 1'b0);
						pred_mode = MODE_PLAIN;
						clear_numeric();
					end
				end else begin
					emit_byte(pred_value[7:0], 1'b0);
					clear_numeric();
					decode_plain(c, last);
				end
			end
			default: begin
				if (is_hex && pred_digits < HEX_MAX_DIGITS) begin
					pred_value = (pred_value << 4) + 9'(nib);
					pred_digits = pred_digits + 2'd1;
					if (pred_digits >= HEX_MAX_DIGITS || last) begin
						emit_byte(pred_value[7:0], 1'b0);
						pred_mode = MODE_PLAIN;
						clear_numeric();
					end
				end else begin
					emit_byte(pred_value[7:0], 1'b0);
					clear_numeric();
					decode_plain(c, last);
				end
			end
		endcase
		// Close the literal with a terminating zero
		if (last) begin
			emit_byte(8'h00, 1'b1);
			pred_mode = MODE_PLAIN;
			clear_numeric();
		end
	endfunction

	// Build one random literal; most are well formed, some are noise
	function automatic int add_random_literal();
		string      simple_set;
		string      hex_set;
		logic [7:0] lit[$];
		token_t     tok;
		int         tokens;
		int         ndig;
		simple_set = "ntrbfvae\\\"'?";
		hex_set = "0123456789abcdefABCDEF";
		if ($urandom_range(0, 99) < 15) begin
			// Noise: random bytes, last marks anywhere
			tokens = $urandom_range(1, 6);
			for (int i = 0; i < tokens; i++) begin
				add_char(8'($urandom), ($urandom_range(0, 5) == 0));
			end
			return tokens;
		end
		tokens = $urandom_range(1, 6);
		for (int i = 0; i < tokens; i++) begin
			tok = token_t'($urandom_range(TOK_PLAIN, TOK_UNKNOWN));
			case (tok)
				TOK_PLAIN: begin
					lit.push_back(8'($urandom));
				end
				TOK_SIMPLE: begin
					lit.push_back(CHAR_BSLASH);
					lit.push_back(simple_set[$urandom_range(0, simple_set.len() - 1)]);
				end
				TOK_OCT: begin
					lit.push_back(CHAR_BSLASH);
					ndig = $urandom_range(1, 3);
					for (int d = 0; d < ndig; d++) lit.push_back(CHAR_0 + 8'($urandom_range(0, 7)));
				end
				TOK_HEX: begin
					lit.push_back(CHAR_BSLASH);
					lit.push_back($urandom_range(0, 1) ? CHAR_LX : CHAR_UX);
					ndig = $urandom_range(0, 2);
					for (int d = 0; d < ndig; d++) lit.push_back(hex_set[$urandom_range(0, 21)]);
				end
				default: begin
					lit.push_back(CHAR_BSLASH);
					lit.push_back(8'($urandom));
				end
			endcase
		end
		// Sometimes end on a lone backslash
		if ($urandom_range(0, 9) == 0) lit.push_back(CHAR_BSLASH);
		foreach (lit[i]) add_char(lit[i], (i == lit.size() - 1));
		return lit.size();
	endfunction

	// Monitor: predict accepted requests, check popped bytes, watch the limit
	always @(posedge clk) begin : monitor
		dec_byte_t exp_b;
		if (arst_n) begin
			cycle_count++;
			if (push && !full) begin
				decode_char(char_in, char_last);
				void'(pending_chars.pop_front());
			end
			push_stalled = push && full;
			if (pop && !empty) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h last %0b", byte_out, byte_last));
				end else begin
					exp_b = expected_bytes.pop_front();
					if (byte_out !== exp_b.value)
						report_mismatch($sformatf("byte_out %02h, want %02h", byte_out, exp_b.value));
					if (byte_last !== exp_b.last)
						report_mismatch($sformatf("byte_last %0b, want %0b", byte_last, exp_b.last));
				end
			end
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Driver: send pending characters in bursts, hold a stalled request
	always @(negedge clk) begin : driver
		logic nxt_push;
		nxt_push = 1'b0;
		if (arst_n) begin
			if (push_stalled) begin
				nxt_push = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (pending_chars.size() > 0) begin
				nxt_push = 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					burst_left = $urandom_range(1, 24);
				end
			end
		end
		push <= nxt_push;
		if (nxt_push) begin
			char_in <= pending_chars[0].ch;
			char_last <= pending_chars[0].last;
		end
	end

	// Receiver: switch between free flow, random stalls and slow draining
	always @(negedge clk) begin : receiver
		logic nxt_pop;
		nxt_pop = 1'b0;
		if (arst_n) begin
			if (rx_phase_left <= 0) begin
				rx_pattern = rx_pattern_t'($urandom_range(RX_FREE, RX_SLOW));
				rx_phase_left = $urandom_range(10, 80);
			end
			rx_phase_left--;
			case (rx_pattern)
				RX_FREE:   nxt_pop = 1'b1;
				RX_RANDOM: nxt_pop = $urandom_range(0, 1);
				default: begin
					rx_slow_count++;
					nxt_pop = (rx_slow_count % 7 == 0);
				end
			endcase
		end
		pop <= nxt_pop;
	end

	// Stimulus, reset and end of run
	initial begin : stimulus
		int rand_items;
		// Extremes of the byte range
		add_char(8'h00, 1'b0);
		add_char(8'hFF, 1'b1);
		// Escape byte, unknown escape, full octal overflow then a non-digit
		add_char(CHAR_BSLASH, 1'b0);
		add_char("e", 1'b0);
		add_char(CHAR_BSLASH, 1'b0);
		add_char("q", 1'b0);
		add_char(CHAR_BSLASH, 1'b0);
		add_char(CHAR_7, 1'b0);
		add_char(CHAR_7, 1'b0);
		add_char(CHAR_7, 1'b0);
		add_char("8", 1'b1);
		// Hex escape with no digits, then plain text
		add_char(CHAR_BSLASH, 1'b0);
		add_char(CHAR_LX, 1'b0);
		add_char("G", 1'b1);
		// Hex escape at full length
		add_char(CHAR_BSLASH, 1'b0);
		add_char(CHAR_UX, 1'b0);
		add_char("a", 1'b0);
		add_char(CHAR_UF, 1'b1);
		// Octal flushed by a trailing backslash: three bytes from one request
		add_char(CHAR_BSLASH, 1'b0);
		add_char("1", 1'b0);
		add_char(CHAR_BSLASH, 1'b1);
		// Lone backslash as the whole literal
		add_char(CHAR_BSLASH, 1'b1);
		// Hex escape cut off by the end of the literal
		add_char(CHAR_BSLASH, 1'b0);
		add_char(CHAR_LX, 1'b1);

		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) rand_items += add_random_literal();
		// Leave the decoder in plain text
		add_char("Z", 1'b1);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_chars.size() != 0 || push) @(posedge clk);
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### files.f
+incdir+design
design/esd_pkg.sv
design/esd_front.sv
design/esd_fifo.sv
design/esd_back.sv
design/escape_sequence_decoder.sv
design/esd_checker.sv
verif/tb_escape_sequence_decoder.sv
